>>> sv/nfa_pattern_matcher_macros.svh
// Assertion macros for the NFA pattern matcher checker.
// Each macro expects i_clk and i_rst_n in scope of the module that uses it.
`ifndef NFA_PATTERN_MATCHER_MACROS_SVH
`define NFA_PATTERN_MATCHER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define NPM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("npm assertion failed");

// Next-cycle implication, disabled while reset is held.
`define NPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("npm assertion failed");

`endif

>>> sv/npm_pkg.sv
// Shared types and codes of the NFA pattern matcher.
// No dependencies; every other file of the block but the macro header uses it.
`default_nettype none

package npm_pkg;

    localparam int SYM_W   = 21;
    localparam int IDX_W   = 6;
    localparam int KIND_W  = 3;
    localparam int COUNT_W = 7;

    // Request types.
    localparam logic [1:0] REQ_LOAD_NODE = 2'd0;
    localparam logic [1:0] REQ_LOAD_IV   = 2'd1;
    localparam logic [1:0] REQ_SYMBOL    = 2'd2;
    localparam logic [1:0] REQ_END       = 2'd3;

    // Node kinds.
    localparam logic [KIND_W-1:0] KIND_LITERAL  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WILDCARD = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLASS    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SPLIT    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MATCH    = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_START_NODE = 1'b0;
    localparam logic CFG_AUTOMATON  = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SYM_W-1:0]   lit;
        logic [IDX_W-1:0]   next_first;
        logic [IDX_W-1:0]   next_second;
        logic [IDX_W-1:0]   class_base;
        logic [COUNT_W-1:0] class_count;
    } t_node;

    typedef struct packed {
        logic [SYM_W-1:0] lo;
        logic [SYM_W-1:0] hi;
    } t_iv;

    // Table write request from the sequencer.
    typedef struct packed {
        logic             node_we;
        logic [IDX_W-1:0] node_addr;
        t_node            node;
        logic             iv_we;
        logic [IDX_W-1:0] iv_addr;
        t_iv              iv;
    } t_tbl_wr;

endpackage

`default_nettype wire

>>> sv/npm_ifs.sv
// Channel interfaces of the NFA pattern matcher: requests, results, config.
// Depends on npm_pkg for field widths.
`default_nettype none

interface npm_req_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       req_type;
    logic [npm_pkg::IDX_W-1:0]        node_index;
    logic [npm_pkg::KIND_W-1:0]       node_kind;
    logic [npm_pkg::SYM_W-1:0]        symbol;
    logic [npm_pkg::IDX_W-1:0]        next_first;
    logic [npm_pkg::IDX_W-1:0]        next_second;
    logic [npm_pkg::IDX_W-1:0]        class_base;
    logic [npm_pkg::COUNT_W-1:0]      class_count;
    logic [npm_pkg::IDX_W-1:0]        interval_index;
    logic [npm_pkg::SYM_W-1:0]        interval_low;
    logic [npm_pkg::SYM_W-1:0]        interval_high;

    modport source (output valid, req_type, node_index, node_kind, symbol, next_first,
                    next_second, class_base, class_count, interval_index, interval_low,
                    interval_high, input ready);
    modport sink   (input valid, req_type, node_index, node_kind, symbol, next_first,
                    next_second, class_base, class_count, interval_index, interval_low,
                    interval_high, output ready);
endinterface

interface npm_res_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, matched, input ready);
    modport sink   (input valid, matched, output ready);
endinterface

interface npm_cfg_if;
    logic                      valid;
    logic                      ready;
    logic                      index;
    logic [npm_pkg::IDX_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/npm_tables.sv
// Node and interval tables, one write and one registered read port each.
// Depends on npm_pkg.
`default_nettype none

module npm_tables #(
    parameter int MAX_NODES     = 64,
    parameter int MAX_INTERVALS = 64,
    parameter int NW            = $clog2(MAX_NODES),
    parameter int IW            = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1
) (
    input  wire logic             i_clk,
    input  wire npm_pkg::t_tbl_wr i_wr,
    input  wire logic [NW-1:0]    i_node_raddr,
    input  wire logic [IW-1:0]    i_iv_raddr,
    output npm_pkg::t_node        o_node_rd,
    output npm_pkg::t_iv          o_iv_rd
);

    npm_pkg::t_node r_node_mem [MAX_NODES];
    npm_pkg::t_iv   r_iv_mem   [MAX_INTERVALS];

    always_ff @(posedge i_clk) begin
        if (i_wr.node_we && (32'(i_wr.node_addr) < MAX_NODES)) begin
            r_node_mem[NW'(i_wr.node_addr)] <= i_wr.node;
        end
        o_node_rd <= r_node_mem[i_node_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.iv_we && (32'(i_wr.iv_addr) < MAX_INTERVALS)) begin
            r_iv_mem[IW'(i_wr.iv_addr)] <= i_wr.iv;
        end
        o_iv_rd <= r_iv_mem[i_iv_raddr];
    end

endmodule

`default_nettype wire

>>> sv/npm_cmp.sv
// Shared code-point compare unit: literal equality and interval containment.
// Depends on npm_pkg for widths.
`default_nettype none

module npm_cmp (
    input  wire logic [npm_pkg::SYM_W-1:0] i_sym,
    input  wire logic [npm_pkg::SYM_W-1:0] i_lit,
    input  wire logic [npm_pkg::SYM_W-1:0] i_lo,
    input  wire logic [npm_pkg::SYM_W-1:0] i_hi,
    output logic                           o_lit_eq,
    output logic                           o_in_range
);

    assign o_lit_eq   = (i_sym == i_lit);
    // An interval with its low end above its high end holds nothing.
    assign o_in_range = (i_lo <= i_sym) && (i_sym <= i_hi);

endmodule

`default_nettype wire

>>> sv/npm_ctrl.sv
// Sequencer of the NFA pattern matcher: handshakes, configuration, active
// set, split closure passes, symbol step and match scan. Depends on npm_pkg.
`default_nettype none

module npm_ctrl #(
    parameter int MAX_NODES     = 64,
    parameter int MAX_INTERVALS = 64,
    parameter int NW            = $clog2(MAX_NODES),
    parameter int IW            = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    npm_req_if.sink                        req,
    npm_res_if.source                      res,
    npm_cfg_if.sink                        cfg,
    output npm_pkg::t_tbl_wr               o_wr,
    output logic [NW-1:0]                  o_node_raddr,
    output logic [IW-1:0]                  o_iv_raddr,
    input  wire npm_pkg::t_node            i_node_rd,
    output logic [npm_pkg::SYM_W-1:0]      o_sym,
    input  wire logic                      i_lit_eq,
    input  wire logic                      i_in_range
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CL_INIT, ST_CL_RD, ST_CL_EX,
        ST_SC_RD, ST_SC_EX, ST_IV_RD, ST_IV_EX, ST_OUT
    } t_state;

    t_state                          r_state, n_state;
    logic [NW-1:0]                   r_idx, n_idx;
    logic [npm_pkg::COUNT_W-1:0]     r_k, n_k;
    logic [MAX_NODES-1:0]            r_pend, n_pend;
    logic [MAX_NODES-1:0]            r_seen, n_seen;
    logic [MAX_NODES-1:0]            r_clo, n_clo;
    logic [MAX_NODES-1:0]            r_act, n_act;
    logic [MAX_NODES-1:0]            r_nxt, n_nxt;
    logic                            r_fresh, n_fresh;
    logic [npm_pkg::IDX_W-1:0]       r_start, n_start;
    logic                            r_present, n_present;
    logic                            r_is_end, n_is_end;
    logic                            r_hit, n_hit;
    logic [npm_pkg::SYM_W-1:0]       r_sym, n_sym;
    logic                            r_out_valid, n_out_valid;
    logic                            r_matched, n_matched;

    logic                            w_last;
    logic                            w_adv_cl;
    logic                            w_adv_sc;
    logic                            w_take;
    logic [npm_pkg::IDX_W+1:0]       w_iv_sum;

    assign req.ready    = (r_state == ST_IDLE);
    assign cfg.ready    = 1'b1;
    assign res.valid    = r_out_valid;
    assign res.matched  = r_matched;
    assign o_node_raddr = r_idx;
    assign o_sym        = r_sym;

    assign w_last   = (r_idx == NW'(MAX_NODES - 1));
    assign w_iv_sum = (npm_pkg::IDX_W+2)'(i_node_rd.class_base) + (npm_pkg::IDX_W+2)'(r_k);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_k         = r_k;
        n_pend      = r_pend;
        n_seen      = r_seen;
        n_clo       = r_clo;
        n_act       = r_act;
        n_nxt       = r_nxt;
        n_fresh     = r_fresh;
        n_start     = r_start;
        n_present   = r_present;
        n_is_end    = r_is_end;
        n_hit       = r_hit;
        n_sym       = r_sym;
        n_out_valid = r_out_valid;
        n_matched   = r_matched;
        o_iv_raddr  = '0;
        w_adv_cl    = 1'b0;
        w_adv_sc    = 1'b0;
        w_take      = 1'b0;

        o_wr           = '0;
        o_wr.node_addr = req.node_index;
        o_wr.node.kind        = req.node_kind;
        o_wr.node.lit         = req.symbol;
        o_wr.node.next_first  = req.next_first;
        o_wr.node.next_second = req.next_second;
        o_wr.node.class_base  = req.class_base;
        o_wr.node.class_count = req.class_count;
        o_wr.iv_addr   = req.interval_index;
        o_wr.iv.lo     = req.interval_low;
        o_wr.iv.hi     = req.interval_high;

        if (cfg.valid) begin
            case (cfg.index)
                npm_pkg::CFG_START_NODE: n_start   = cfg.data;
                npm_pkg::CFG_AUTOMATON:  n_present = cfg.data[0];
                default: ;
            endcase
        end

        if (r_out_valid && res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (req.valid) begin
                    case (req.req_type)
                        npm_pkg::REQ_LOAD_NODE: o_wr.node_we = 1'b1;
                        npm_pkg::REQ_LOAD_IV:   o_wr.iv_we   = 1'b1;
                        default: begin
                            n_sym    = req.symbol;
                            n_is_end = (req.req_type == npm_pkg::REQ_END);
                            n_hit    = r_fresh && !r_present;
                            if (r_fresh) begin
                                n_act = '0;
                                if (r_present && (32'(r_start) < MAX_NODES)) begin
                                    n_act[NW'(r_start)] = 1'b1;
                                end
                                n_fresh = 1'b0;
                            end
                            n_state = ST_CL_INIT;
                        end
                    endcase
                end
            end
            ST_CL_INIT: begin
                n_pend  = r_act;
                n_seen  = r_act;
                n_clo   = '0;
                n_idx   = '0;
                n_state = ST_CL_RD;
            end
            ST_CL_RD: begin
                if (r_pend[r_idx]) begin
                    n_state = ST_CL_EX;
                end else begin
                    w_adv_cl = 1'b1;
                end
            end
            ST_CL_EX: begin
                n_pend[r_idx] = 1'b0;
                if (i_node_rd.kind != npm_pkg::KIND_SPLIT) begin
                    n_clo[r_idx] = 1'b1;
                end else begin
                    if ((32'(i_node_rd.next_first) < MAX_NODES)
                            && !n_seen[NW'(i_node_rd.next_first)]) begin
                        n_seen[NW'(i_node_rd.next_first)] = 1'b1;
                        n_pend[NW'(i_node_rd.next_first)] = 1'b1;
                    end
                    if ((32'(i_node_rd.next_second) < MAX_NODES)
                            && !n_seen[NW'(i_node_rd.next_second)]) begin
                        n_seen[NW'(i_node_rd.next_second)] = 1'b1;
                        n_pend[NW'(i_node_rd.next_second)] = 1'b1;
                    end
                end
                w_adv_cl = 1'b1;
            end
            ST_SC_RD: begin
                if (r_act[r_idx]) begin
                    n_state = ST_SC_EX;
                end else begin
                    w_adv_sc = 1'b1;
                end
            end
            ST_SC_EX: begin
                if (r_is_end) begin
                    if (i_node_rd.kind == npm_pkg::KIND_MATCH) begin
                        n_hit = 1'b1;
                    end
                    w_adv_sc = 1'b1;
                end else begin
                    case (i_node_rd.kind)
                        npm_pkg::KIND_LITERAL: begin
                            w_take   = i_lit_eq;
                            w_adv_sc = 1'b1;
                        end
                        npm_pkg::KIND_WILDCARD: begin
                            w_take   = 1'b1;
                            w_adv_sc = 1'b1;
                        end
                        npm_pkg::KIND_CLASS: begin
                            n_k     = '0;
                            n_state = ST_IV_RD;
                        end
                        default: w_adv_sc = 1'b1;
                    endcase
                end
            end
            ST_IV_RD: begin
                if (r_k >= i_node_rd.class_count) begin
                    w_adv_sc = 1'b1;
                end else if (32'(w_iv_sum) >= MAX_INTERVALS) begin
                    n_k = r_k + 1'b1;
                end else begin
                    o_iv_raddr = IW'(w_iv_sum);
                    n_state    = ST_IV_EX;
                end
            end
            ST_IV_EX: begin
                if (i_in_range) begin
                    w_take   = 1'b1;
                    w_adv_sc = 1'b1;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_IV_RD;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || res.ready) begin
                    n_out_valid = 1'b1;
                    n_matched   = r_hit;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (w_take && (32'(i_node_rd.next_first) < MAX_NODES)) begin
            n_nxt[NW'(i_node_rd.next_first)] = 1'b1;
        end

        // Step through the closure pass; at its end, run another while work is pending.
        if (w_adv_cl) begin
            if (w_last) begin
                n_idx = '0;
                if (|n_pend) begin
                    n_state = ST_CL_RD;
                end else begin
                    n_act   = n_clo;
                    n_nxt   = '0;
                    n_state = ST_SC_RD;
                end
            end else begin
                n_idx   = r_idx + 1'b1;
                n_state = ST_CL_RD;
            end
        end

        if (w_adv_sc) begin
            if (w_last) begin
                n_idx = '0;
                if (r_is_end) begin
                    n_act   = '0;
                    n_fresh = 1'b1;
                    n_state = ST_OUT;
                end else begin
                    n_act   = n_nxt;
                    n_state = ST_IDLE;
                end
            end else begin
                n_idx   = r_idx + 1'b1;
                n_state = ST_SC_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_k         <= '0;
            r_pend      <= '0;
            r_seen      <= '0;
            r_clo       <= '0;
            r_act       <= '0;
            r_nxt       <= '0;
            r_fresh     <= 1'b1;
            r_start     <= '0;
            r_present   <= 1'b0;
            r_is_end    <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_k         <= n_k;
            r_pend      <= n_pend;
            r_seen      <= n_seen;
            r_clo       <= n_clo;
            r_act       <= n_act;
            r_nxt       <= n_nxt;
            r_fresh     <= n_fresh;
            r_start     <= n_start;
            r_present   <= n_present;
            r_is_end    <= n_is_end;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
        r_sym     <= n_sym;
        r_matched <= n_matched;
    end

endmodule

`default_nettype wire

>>> sv/nfa_pattern_matcher.sv
// NFA pattern matcher, top level.
// Depends on npm_pkg, the channel interfaces, npm_tables, npm_cmp, npm_ctrl.
//
// Usage: i_req carries one word per request. Load-node and load-interval
// words write the node or interval table and leave i_req ready for the next word.
// A symbol word advances the active set; an end word closes the active set,
// returns one word on o_res (matched) and rearms the start node for the
// next string. i_cfg writes start_node (index 0) and automaton_present
// (index 1); it is always ready, and writes belong between strings.
// A symbol or end word is accepted and passes a setup state, then closure
// passes over all MAX_NODES node indexes, with an extra step for each node
// pending in the pass, run until split chains settle, then a scan over all
// nodes with an extra step for each active node. An active class node reads
// and tests its intervals one by one, skipping interval indexes out of range.
// An end word then loads the result in an output state. One word is in work
// at a time and i_req.ready stays low until it is done.
// Reset clears the active set, the configuration and any pending result;
// the tables hold whatever was written and must be loaded before use.
// A stalled o_res holds its word; load and symbol words are still accepted,
// and an end word waits at its finish until the output register is free.
`default_nettype none

module nfa_pattern_matcher #(
    parameter int MAX_NODES     = 64,
    parameter int MAX_INTERVALS = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    npm_req_if.sink   i_req,
    npm_res_if.source o_res,
    npm_cfg_if.sink   i_cfg
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;

    npm_pkg::t_tbl_wr            w_wr;
    logic [NW-1:0]               w_node_raddr;
    logic [IW-1:0]               w_iv_raddr;
    npm_pkg::t_node              w_node_rd;
    npm_pkg::t_iv                w_iv_rd;
    logic [npm_pkg::SYM_W-1:0]   w_sym;
    logic                        w_lit_eq;
    logic                        w_in_range;

    // Sequencer: owns the handshakes, the active set and the closure passes.
    npm_ctrl #(
        .MAX_NODES     (MAX_NODES),
        .MAX_INTERVALS (MAX_INTERVALS),
        .NW            (NW),
        .IW            (IW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (i_req),
        .res          (o_res),
        .cfg          (i_cfg),
        .o_wr         (w_wr),
        .o_node_raddr (w_node_raddr),
        .o_iv_raddr   (w_iv_raddr),
        .i_node_rd    (w_node_rd),
        .o_sym        (w_sym),
        .i_lit_eq     (w_lit_eq),
        .i_in_range   (w_in_range)
    );

    // Node and interval memories with registered read data.
    npm_tables #(
        .MAX_NODES     (MAX_NODES),
        .MAX_INTERVALS (MAX_INTERVALS),
        .NW            (NW),
        .IW            (IW)
    ) u_tables (
        .i_clk        (i_clk),
        .i_wr         (w_wr),
        .i_node_raddr (w_node_raddr),
        .i_iv_raddr   (w_iv_raddr),
        .o_node_rd    (w_node_rd),
        .o_iv_rd      (w_iv_rd)
    );

    // The single compare unit, shared by literal and class tests.
    npm_cmp u_cmp (
        .i_sym      (w_sym),
        .i_lit      (w_node_rd.lit),
        .i_lo       (w_iv_rd.lo),
        .i_hi       (w_iv_rd.hi),
        .o_lit_eq   (w_lit_eq),
        .o_in_range (w_in_range)
    );

endmodule

`default_nettype wire

>>> sv/npm_checker.sv
// Port-level assertions for the NFA pattern matcher, bound to the top level.
// Depends on nfa_pattern_matcher_macros.svh.
`default_nettype none

`include "nfa_pattern_matcher_macros.svh"

module npm_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_req_valid,
    input wire logic       i_req_ready,
    input wire logic [1:0] i_req_type,
    input wire logic       i_res_valid,
    input wire logic       i_res_ready,
    input wire logic       i_res_matched
);

    logic w_req_acc;
    logic w_work;

    assign w_req_acc = i_req_valid && i_req_ready;
    assign w_work    = (i_req_type == npm_pkg::REQ_SYMBOL) || (i_req_type == npm_pkg::REQ_END);

    `NPM_ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_matched))
    `NPM_ASSERT_NEXT(a_busy_after_work, w_req_acc && w_work, !i_req_ready)
    `NPM_ASSERT_NEXT(a_ready_after_load, w_req_acc && !w_work, i_req_ready)
    `NPM_ASSERT_NOW(a_result_after_work, $rose(i_res_valid), $past(!i_req_ready))

endmodule

bind nfa_pattern_matcher npm_checker u_npm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_req_type    (i_req.req_type),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_matched (o_res.matched)
);

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for nfa_pattern_matcher: predicts the matched flag of every
// end-of-string word and compares it; depends on npm_pkg, npm_ifs and the block's RTL.
`default_nettype none

module testbench;
    import npm_pkg::*;

    // One queued stimulus entry: a request word or a configuration write.
    typedef struct {
        bit                 is_cfg;
        logic               cfg_index;
        logic [IDX_W-1:0]   cfg_data;
        logic [1:0]         req_type;
        logic [IDX_W-1:0]   node_index;
        logic [KIND_W-1:0]  node_kind;
        logic [SYM_W-1:0]   symbol;
        logic [IDX_W-1:0]   next_first;
        logic [IDX_W-1:0]   next_second;
        logic [IDX_W-1:0]   class_base;
        logic [COUNT_W-1:0] class_count;
        logic [IDX_W-1:0]   interval_index;
        logic [SYM_W-1:0]   interval_low;
        logic [SYM_W-1:0]   interval_high;
    } t_word;

    localparam int SETTLE_CYCLES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    npm_req_if rq();
    npm_res_if rs();
    npm_cfg_if cf();

    nfa_pattern_matcher u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rq),
        .o_res   (rs),
        .i_cfg   (cf)
    );

    always #2 i_clk = ~i_clk;

    // Stimulus waiting to be driven, and the matched flags still owed by the block.
    t_word pending_words[$];
    bit    match_expect[$];

    // Shadow copy of the block's state: tables, active set, configuration.
    t_node            node_shadow[64];
    t_iv              iv_shadow[64];
    logic [63:0]      live_nodes;
    bit               fresh_string;
    logic [IDX_W-1:0] start_shadow;
    bit               present_shadow;

    // Symbols the current random automaton is built around.
    logic [SYM_W-1:0] alpha[4];

    int mismatches;
    int words_sent;
    int ends_checked;
    int hits_seen;

    // Closes a node set over split nodes: each split is replaced by the
    // non-split nodes reachable through chains of splits. Every node enters
    // the work list at most once, so 64 slots are enough.
    function automatic logic [63:0] close_over_splits(logic [63:0] s);
        logic [63:0] seen;
        logic [63:0] res;
        int          work_list[64];
        int          depth;
        int          n;
        int          succ;
        seen = '0;
        res = '0;
        depth = 0;
        for (int i = 0; i < 64; i++) begin
            if (s[i]) begin
                if (node_shadow[i].kind != KIND_SPLIT) res[i] = 1'b1;
                else if (!seen[i]) begin
                    seen[i] = 1'b1;
                    work_list[depth] = i;
                    depth++;
                end
            end
        end
        while (depth > 0) begin
            depth--;
            n = work_list[depth];
            if (node_shadow[n].kind != KIND_SPLIT) begin
                res[n] = 1'b1;
            end else begin
                for (int k = 0; k < 2; k++) begin
                    succ = (k == 0) ? int'(node_shadow[n].next_first)
                                    : int'(node_shadow[n].next_second);
                    if (!seen[succ]) begin
                        seen[succ] = 1'b1;
                        work_list[depth] = succ;
                        depth++;
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic bit class_accepts(t_node nd, logic [SYM_W-1:0] c);
        int idx;
        for (int k = 0; k < int'(nd.class_count); k++) begin
            idx = int'(nd.class_base) + k;
            if (idx < 64 && iv_shadow[idx].lo <= c && c <= iv_shadow[idx].hi) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void arm_string();
        if (fresh_string) begin
            live_nodes = '0;
            if (present_shadow) live_nodes[start_shadow] = 1'b1;
            fresh_string = 1'b0;
        end
    endfunction

    // Applies one accepted request word to the shadow state; an end word
    // queues the matched flag the block must return.
    function automatic void advance_matcher(t_word w);
        logic [63:0] nxt;
        bit          take;
        bit          hit;
        bit          was_fresh;
        t_node       nd;
        case (w.req_type)
            REQ_LOAD_NODE: begin
                nd.kind = w.node_kind;
                nd.lit = w.symbol;
                nd.next_first = w.next_first;
                nd.next_second = w.next_second;
                nd.class_base = w.class_base;
                nd.class_count = w.class_count;
                node_shadow[w.node_index] = nd;
            end
            REQ_LOAD_IV: begin
                iv_shadow[w.interval_index].lo = w.interval_low;
                iv_shadow[w.interval_index].hi = w.interval_high;
            end
            REQ_SYMBOL: begin
                arm_string();
                live_nodes = close_over_splits(live_nodes);
                nxt = '0;
                for (int i = 0; i < 64; i++) begin
                    if (live_nodes[i]) begin
                        nd = node_shadow[i];
                        take = (nd.kind == KIND_LITERAL && nd.lit == w.symbol) ||
                               nd.kind == KIND_WILDCARD ||
                               (nd.kind == KIND_CLASS && class_accepts(nd, w.symbol));
                        if (take) nxt[nd.next_first] = 1'b1;
                    end
                end
                live_nodes = nxt;
            end
            default: begin
                was_fresh = fresh_string;
                hit = 1'b0;
                arm_string();
                live_nodes = close_over_splits(live_nodes);
                for (int i = 0; i < 64; i++)
                    if (live_nodes[i] && node_shadow[i].kind == KIND_MATCH) hit = 1'b1;
                if (was_fresh && !present_shadow) hit = 1'b1;
                live_nodes = '0;
                fresh_string = 1'b1;
                match_expect.push_back(hit);
            end
        endcase
    endfunction

    // Stall draws: every 64 draws it is picked at random whether the next stretch
    // runs flat out or with random gaps, so both dense and sparse traffic occur.
    int send_draws = 0;
    bit send_quiet = 0;
    int recv_draws = 0;
    bit recv_quiet = 0;

    function automatic int send_gap();
        send_draws++;
        if (send_draws % 64 == 0) send_quiet = ($urandom_range(0, 3) == 0);
        return send_quiet ? 0 : int'($urandom_range(0, 13));
    endfunction

    function automatic int recv_gap();
        recv_draws++;
        if (recv_draws % 64 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
        return recv_quiet ? 0 : int'($urandom_range(0, 13));
    endfunction

    // Word builders.
    function automatic t_word blank_word();
        t_word w;
        w = '{default: '0};
        w.node_index = IDX_W'($urandom_range(0, 63));
        w.interval_index = IDX_W'($urandom_range(0, 63));
        w.node_kind = KIND_W'($urandom_range(0, 7));
        w.next_first = IDX_W'($urandom_range(0, 63));
        w.next_second = IDX_W'($urandom_range(0, 63));
        w.class_base = IDX_W'($urandom_range(0, 63));
        w.class_count = COUNT_W'($urandom_range(0, 127));
        w.interval_low = SYM_W'($urandom_range(0, 1114111));
        w.interval_high = SYM_W'($urandom_range(0, 1114111));
        w.symbol = SYM_W'($urandom_range(0, 1114111));
        return w;
    endfunction

    task automatic push_node(int idx, logic [KIND_W-1:0] kind, logic [SYM_W-1:0] lit,
                             int nf, int ns, int base, int cnt);
        t_word w;
        w = blank_word();
        w.req_type = REQ_LOAD_NODE;
        w.node_index = IDX_W'(idx);
        w.node_kind = kind;
        w.symbol = lit;
        w.next_first = IDX_W'(nf);
        w.next_second = IDX_W'(ns);
        w.class_base = IDX_W'(base);
        w.class_count = COUNT_W'(cnt);
        pending_words.push_back(w);
    endtask

    task automatic push_iv(int idx, logic [SYM_W-1:0] lo, logic [SYM_W-1:0] hi);
        t_word w;
        w = blank_word();
        w.req_type = REQ_LOAD_IV;
        w.interval_index = IDX_W'(idx);
        w.interval_low = lo;
        w.interval_high = hi;
        pending_words.push_back(w);
    endtask

    task automatic push_sym(logic [SYM_W-1:0] c);
        t_word w;
        w = blank_word();
        w.req_type = REQ_SYMBOL;
        w.symbol = c;
        pending_words.push_back(w);
    endtask

    task automatic push_end();
        t_word w;
        w = blank_word();
        w.req_type = REQ_END;
        pending_words.push_back(w);
    endtask

    task automatic push_cfg(logic idx, logic [IDX_W-1:0] data);
        t_word w;
        w = '{default: '0};
        w.is_cfg = 1'b1;
        w.cfg_index = idx;
        w.cfg_data = data;
        pending_words.push_back(w);
    endtask

    // A random node of the current automaton. Literals mostly carry one of
    // the alphabet symbols so that random strings actually walk the graph.
    task automatic push_rand_node(int idx);
        int pick;
        logic [KIND_W-1:0] kind;
        int cnt;
        pick = $urandom_range(0, 99);
        if (pick < 35) kind = KIND_LITERAL;
        else if (pick < 45) kind = KIND_WILDCARD;
        else if (pick < 60) kind = KIND_CLASS;
        else if (pick < 80) kind = KIND_SPLIT;
        else if (pick < 95) kind = KIND_MATCH;
        else kind = KIND_W'($urandom_range(5, 7));
        pick = $urandom_range(0, 19);
        cnt = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(5, 127) : $urandom_range(1, 4);
        push_node(idx, kind,
                  ($urandom_range(0, 9) == 0) ? SYM_W'($urandom) : alpha[$urandom_range(0, 3)],
                  $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63), cnt);
    endtask

    task automatic push_rand_iv(int idx);
        logic [SYM_W-1:0] lo;
        int pick;
        pick = $urandom_range(0, 9);
        lo = alpha[$urandom_range(0, 3)] - SYM_W'($urandom_range(0, 2));
        if (pick == 0) push_iv(idx, lo + SYM_W'(3), lo);             // empty interval
        else if (pick == 1) push_iv(idx, SYM_W'($urandom), SYM_W'($urandom));
        else push_iv(idx, lo, lo + SYM_W'($urandom_range(0, 4)));
    endtask

    task automatic new_alphabet();
        for (int k = 0; k < 4; k++) alpha[k] = SYM_W'($urandom_range(2, 1114100));
        if ($urandom_range(0, 1)) alpha[0] = 21'h61;
    endtask

    // Driver. The request and configuration channels are served from the
    // same queue in order; a configuration write waits until every result is
    // back and the block has had time to settle.
    t_word cur_word;
    bit    sending = 0;
    bit    cfg_sending = 0;
    int    hold_off = 0;
    int    settle = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rq.valid <= 1'b0;
            cf.valid <= 1'b0;
        end else begin
            if (sending && rq.ready) begin
                advance_matcher(cur_word);
                words_sent++;
                sending = 0;
                hold_off = send_gap();
            end
            if (cfg_sending && cf.ready) begin
                if (cur_word.cfg_index == CFG_START_NODE) start_shadow = cur_word.cfg_data;
                else present_shadow = cur_word.cfg_data[0];
                cfg_sending = 0;
            end
            if (!sending && !cfg_sending) begin
                if (hold_off > 0) begin
                    hold_off--;
                end else if (pending_words.size() > 0) begin
                    if (pending_words[0].is_cfg) begin
                        if (match_expect.size() != 0) settle = 0;
                        else if (settle < SETTLE_CYCLES) settle++;
                        else begin
                            cur_word = pending_words.pop_front();
                            cf.index <= cur_word.cfg_index;
                            cf.data <= cur_word.cfg_data;
                            cfg_sending = 1;
                            settle = 0;
                        end
                    end else begin
                        cur_word = pending_words.pop_front();
                        rq.req_type <= cur_word.req_type;
                        rq.node_index <= cur_word.node_index;
                        rq.node_kind <= cur_word.node_kind;
                        rq.symbol <= cur_word.symbol;
                        rq.next_first <= cur_word.next_first;
                        rq.next_second <= cur_word.next_second;
                        rq.class_base <= cur_word.class_base;
                        rq.class_count <= cur_word.class_count;
                        rq.interval_index <= cur_word.interval_index;
                        rq.interval_low <= cur_word.interval_low;
                        rq.interval_high <= cur_word.interval_high;
                        sending = 1;
                    end
                end
            end
            rq.valid <= sending;
            cf.valid <= cfg_sending;
        end
    end

    // Monitor. Every accepted result word is checked against the oldest
    // outstanding flag; the receiver then holds ready low for a stall drawn by recv_gap.
    int recv_stall = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rs.ready <= 1'b0;
        end else begin
            if (rs.valid && rs.ready) begin
                if (match_expect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result word with none expected: matched=%0b", rs.matched);
                end else begin
                    if (rs.matched !== match_expect[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("end of string %0d: matched expected %0b, got %0b",
                                     ends_checked, match_expect[0], rs.matched);
                    end
                    if (match_expect[0]) hits_seen++;
                    void'(match_expect.pop_front());
                end
                ends_checked++;
                recv_stall = recv_gap();
            end else if (recv_stall > 0) begin
                recv_stall--;
            end
            rs.ready <= (recv_stall == 0);
        end
    end

    // Stimulus and end of run.
    initial begin
        int len;
        rq.valid = 1'b0;
        rq.req_type = REQ_END;
        rq.node_index = '0;
        rq.node_kind = '0;
        rq.symbol = '0;
        rq.next_first = '0;
        rq.next_second = '0;
        rq.class_base = '0;
        rq.class_count = '0;
        rq.interval_index = '0;
        rq.interval_low = '0;
        rq.interval_high = '0;
        rs.ready = 1'b0;
        cf.valid = 1'b0;
        cf.index = CFG_START_NODE;
        cf.data = '0;
        mismatches = 0;
        words_sent = 0;
        ends_checked = 0;
        hits_seen = 0;
        live_nodes = '0;
        fresh_string = 1'b1;
        start_shadow = '0;
        present_shadow = 1'b0;

        // Both tables are filled completely first, so no string ever reads
        // an entry that was never written.
        new_alphabet();
        for (int i = 0; i < 64; i++) push_rand_iv(i);
        for (int i = 0; i < 64; i++) push_rand_node(i);

        // Without an automaton only the empty string matches.
        push_end();
        push_sym(21'h61);
        push_end();

        // A small automaton: a split at node 0 into a literal 'a' and a class
        // of digits or the top code point, both leading to a match at node 2.
        push_node(0, KIND_SPLIT, 21'h0, 1, 3, 0, 0);
        push_node(1, KIND_LITERAL, 21'h61, 2, 0, 0, 0);
        push_node(2, KIND_MATCH, 21'h0, 0, 0, 0, 0);
        push_node(3, KIND_CLASS, 21'h0, 2, 0, 62, 4);
        push_node(4, KIND_WILDCARD, 21'h0, 2, 0, 0, 0);
        push_node(5, 3'd7, 21'h1FFFFF, 2, 2, 0, 0);
        push_iv(62, 21'h30, 21'h39);
        push_iv(63, 21'h10FFFF, 21'h10FFFF);
        push_iv(0, 21'h5, 21'h4);
        push_node(63, KIND_MATCH, 21'h0, 63, 63, 63, 127);
        push_cfg(CFG_AUTOMATON, 6'h3F);
        push_end();                                  // empty string, no match node
        push_sym(21'h61); push_end();
        push_sym(21'h35); push_end();
        push_sym(21'h10FFFF); push_end();
        push_sym(21'h1FFFFF); push_end();
        push_sym(21'h61); push_sym(21'h61); push_end();
        push_cfg(CFG_START_NODE, 6'd4);
        push_sym(21'h0); push_end();                 // wildcard accepts zero
        push_cfg(CFG_START_NODE, 6'd63);
        push_end();                                  // start node is itself a match
        push_cfg(CFG_START_NODE, 6'd5);
        push_sym(21'h61); push_end();                // unknown kind accepts nothing

        // Random part: each round reshapes part of the automaton, then runs a
        // few strings over its alphabet with occasional stray symbols. Every
        // few rounds the configuration is changed, always after an end word.
        for (int round = 0; pending_words.size() + words_sent < 1050; round++) begin
            if (round % 8 == 0) begin
                case ((round / 8) % 4)
                    0: push_cfg(CFG_START_NODE, 6'd0);
                    1: push_cfg(CFG_START_NODE, 6'd63);
                    default: push_cfg(CFG_START_NODE, IDX_W'($urandom_range(0, 63)));
                endcase
                push_cfg(CFG_AUTOMATON, ($urandom_range(0, 4) == 0) ? 6'd0 : 6'd1);
            end
            if (round % 4 == 0) new_alphabet();
            repeat ($urandom_range(3, 10)) begin
                if ($urandom_range(0, 3) == 0) push_rand_iv($urandom_range(0, 63));
                else push_rand_node($urandom_range(0, 63));
            end
            repeat ($urandom_range(2, 4)) begin
                len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
                repeat (len) begin
                    if ($urandom_range(0, 19) == 0) push_sym(SYM_W'($urandom));
                    else push_sym(alpha[$urandom_range(0, 3)]);
                end
                push_end();
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_words.size() == 0 && !sending && !cfg_sending && match_expect.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d words and checked %0d end-of-string results (%0d matched).",
                 words_sent, ends_checked, hits_seen);
        if (mismatches == 0 && match_expect.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

>>> nfa_pattern_matcher.f
+incdir+sv
sv/npm_pkg.sv
sv/npm_ifs.sv
sv/npm_tables.sv
sv/npm_cmp.sv
sv/npm_ctrl.sv
sv/nfa_pattern_matcher.sv
sv/npm_checker.sv
tb/sv/testbench.sv
